// ===== hdl/assoc_cache_tag_replacement_defines.svh =====
// assertion helpers for the cache tag controller
`ifndef ASSOC_CACHE_TAG_REPLACEMENT_DEFINES_SVH
`define ASSOC_CACHE_TAG_REPLACEMENT_DEFINES_SVH

// condition must hold in the same cycle
`define ACTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define ACTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/actr_pkg.sv =====
package actr_pkg;

  localparam int TAG_W  = 32;
  localparam int FREQ_W = 16;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_REVEAL = 2'd2;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_LFU    = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  localparam logic [2:0] CFG_WRITE_BACK_MODE = 3'd0;
  localparam logic [2:0] CFG_REPLACE_POLICY  = 3'd1;
  localparam logic [2:0] CFG_OFFSET_BITS     = 3'd2;
  localparam logic [2:0] CFG_FREQ_COUNT_BITS = 3'd3;
  localparam logic [2:0] CFG_FREQ_INIT_VALUE = 3'd4;
  localparam logic [2:0] CFG_AGING_INTERVAL  = 3'd5;
  localparam logic [2:0] CFG_AGING_SHIFT     = 3'd6;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TAG_W-1:0] address;
    logic [15:0]      random_pick;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [3:0]       entry_index;
    logic             allocated;
    logic [TAG_W-1:0] fill_address;
    logic             writeback_needed;
    logic [TAG_W-1:0] writeback_address;
    logic             forward_write;
  } rsp_t;

  // saturation value for a given counter width, width clamped to 1..16
  function automatic logic [FREQ_W-1:0] freq_max(input logic [4:0] bits);
    logic [4:0] b;
    b = bits;
    if (b == 5'd0) b = 5'd1;
    if (b > 5'd16) b = 5'd16;
    return FREQ_W'((17'd1 << b) - 17'd1);
  endfunction

  function automatic logic [FREQ_W-1:0] freq_inc(input logic [FREQ_W-1:0] f,
                                                 input logic [FREQ_W-1:0] m);
    return (f < m) ? f + 16'd1 : m;
  endfunction

endpackage

// ===== hdl/actr_chan_if.sv =====
interface actr_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/actr_mem.sv =====
module actr_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/actr_div.sv =====
// restoring remainder unit, one quotient bit per cycle
module actr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic        busy;
  logic [3:0]  step;
  logic [15:0] shreg;
  logic [15:0] dvs;
  logic [16:0] trial;

  assign trial = {remainder, shreg[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        shreg     <= dividend;
        dvs       <= divisor;
        remainder <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          remainder <= 16'(trial - {1'b0, dvs});
        end else begin
          remainder <= trial[15:0];
        end
        shreg <= {shreg[14:0], 1'b0};
        step  <= step + 4'd1;
        if (step == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/assoc_cache_tag_replacement.sv =====
// Tag and replacement controller of a fully associative cache. Tag, count
// and usage rank of every entry sit in one entry memory with a registered
// read, and every access works through it in passes of one entry per cycle.
// A hit makes three passes over the next_free valid entries (tag compare,
// insertion point, rank update), and a fill into a free entry makes the same
// passes with the new entry taken into the last one. Once full, an eviction
// adds a pass over all NUM_ENTRIES entries to fetch the victim; under LFU it
// adds another such pass for the run of least counts at the tail and a
// remainder division for the random pick among them, and a read under LFU
// with a nonzero aging period adds such a division as well. Free entries are
// filled in index order before anything is evicted. One item is worked at a
// time; a finished result sits in an output register so the next item can be
// taken while it waits.
`include "assoc_cache_tag_replacement_defines.svh"

module assoc_cache_tag_replacement #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  actr_chan_if.sink   req,
  actr_chan_if.source rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  // reciprocal of the depth, exact for any 16-bit pick
  localparam int RSH = 16 + $clog2(NUM_ENTRIES);
  localparam longint unsigned RCP =
    ((64'd1 << RSH) + 64'(NUM_ENTRIES) - 64'd1) / 64'(NUM_ENTRIES);

  typedef struct packed {
    logic [actr_pkg::TAG_W-1:0]  tag;
    logic [actr_pkg::FREQ_W-1:0] freq;
    logic [IW-1:0]               rank;
  } ent_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_AGEDIV  = 9'b000000010,
    S_SCANA   = 9'b000000100,
    S_SCANB   = 9'b000001000,
    S_PICKDIV = 9'b000010000,
    S_SCANC   = 9'b000100000,
    S_SCAND   = 9'b001000000,
    S_SCANE   = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic        wbm;
  logic [1:0]  policy;
  logic [3:0]  offset_bits;
  logic [4:0]  fcb;
  logic [15:0] finit;
  logic [15:0] aint;
  logic [3:0]  ashift;

  // persistent state beside the memory
  logic [CW-1:0]          next_free;
  logic [15:0]            rc;
  logic [NUM_ENTRIES-1:0] dirty;

  // item context
  logic [1:0]  mode_q;
  logic [31:0] aligned_q;
  logic [15:0] pick_q;
  logic        lfu_q;
  logic        age;
  logic        hit_f;
  logic        alloc_f;
  logic        evict_f;
  logic        new_ent;
  logic        wb_f;
  logic [IW-1:0] hit_idx;
  logic [15:0]   hit_freq;
  logic [IW-1:0] hit_rank;
  logic [15:0]   tail_freq;
  logic [15:0]   least;
  logic          rstar_f;
  logic [IW-1:0] rstar;
  logic          by_rank;
  logic [IW-1:0] tgt;
  logic [IW-1:0] e;
  logic [15:0]   f_new;
  logic          re_valid;
  logic [IW-1:0] re;
  logic [31:0]   vtag;
  logic          pmin_f;
  logic [IW-1:0] pmin;
  logic [CW-1:0] p;

  // scan engine
  logic [CW-1:0] iss;
  logic [CW-1:0] slen;
  logic          pvld;
  logic [IW-1:0] pidx;
  logic          scanning;
  logic          issue;
  logic          scan_done;

  // memory port
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  ent_t          mem_wd;
  ent_t          rd;

  // divider
  logic        div_start;
  logic [15:0] div_a;
  logic [15:0] div_b;
  logic        div_done;
  logic [15:0] div_rem;

  // random pick reduced by the depth
  logic [32:0] pick_prod;
  logic [15:0] pick_quo;
  logic [15:0] pick_rem;

  logic                rsp_valid;
  actr_pkg::rsp_t      rsp_data;

  logic [15:0]   fmax;
  logic [15:0]   init_clamped;
  logic [15:0]   fa;
  logic [IW-1:0] pos;
  logic [IW-1:0] pos_new;
  logic [CW-1:0] cnt;
  logic [CW-1:0] nprime;
  logic          full;
  logic          alloc_req;
  logic [31:0]   e_wide;
  logic [31:0]   aligned_in;

  assign fmax         = actr_pkg::freq_max(fcb);
  assign init_clamped = (finit < fmax) ? finit : fmax;
  assign full         = (next_free == CW'(NUM_ENTRIES));
  assign alloc_req    = (mode_q == actr_pkg::MODE_READ) ||
                        ((mode_q == actr_pkg::MODE_WRITE) && wbm);
  assign aligned_in   = req.data.address & (32'hFFFF_FFFF << offset_bits);
  assign cnt          = rstar_f ? CW'(NUM_ENTRIES - 1) - CW'(rstar) : CW'(NUM_ENTRIES);
  assign nprime       = next_free - CW'(re_valid);
  assign e_wide       = 32'(e);

  assign pick_prod = 33'(pick_q) * 33'(RCP);
  assign pick_rem  = pick_q - 16'(pick_quo * 16'(NUM_ENTRIES));

  assign scanning  = (state == S_SCANA) || (state == S_SCANB) || (state == S_SCANC) ||
                     (state == S_SCAND) || (state == S_SCANE);
  assign issue     = scanning && (iss < slen);
  // the pass ends once no entry is left in flight, so the last write lands before the next pass
  assign scan_done = !pvld && (iss == slen);

  assign fa      = age ? (rd.freq >> ashift) : rd.freq;
  // position in the usage order with the relinked entry taken out
  assign pos     = rd.rank - IW'(re_valid && (rd.rank > re));
  assign pos_new = ({1'b0, pos} < p) ? pos : pos + IW'(1);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pidx;
    mem_wd = rd;
    if (state == S_SCANA) begin
      mem_we      = pvld && age;
      mem_wd.freq = fa;
    end else if (state == S_SCANE) begin
      mem_we = pvld;
      if (pidx == e) begin
        mem_wd.tag  = aligned_q;
        mem_wd.freq = f_new;
        mem_wd.rank = p[IW-1:0];
      end else begin
        mem_wd.rank = pos_new;
      end
    end
  end

  actr_mem #(
    .DEPTH (NUM_ENTRIES),
    .WIDTH ($bits(ent_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (iss[IW-1:0]),
    .rdata (rd)
  );

  actr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wbm         <= 1'b0;
      policy      <= actr_pkg::POL_LRU;
      offset_bits <= 4'd6;
      fcb         <= 5'd8;
      finit       <= 16'd0;
      aint        <= 16'd256;
      ashift      <= 4'd1;
      next_free   <= '0;
      rc          <= '0;
      dirty       <= '0;
      iss         <= '0;
      pvld        <= 1'b0;
      div_start   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      pick_quo  <= 16'(pick_prod >> RSH);

      if (cfg_we) begin
        unique case (cfg_index)
          actr_pkg::CFG_WRITE_BACK_MODE: wbm         <= cfg_data[0];
          actr_pkg::CFG_REPLACE_POLICY:  policy      <= cfg_data[1:0];
          actr_pkg::CFG_OFFSET_BITS:     offset_bits <= cfg_data[3:0];
          actr_pkg::CFG_FREQ_COUNT_BITS: fcb         <= cfg_data[4:0];
          actr_pkg::CFG_FREQ_INIT_VALUE: finit       <= cfg_data;
          actr_pkg::CFG_AGING_INTERVAL:  aint        <= cfg_data;
          actr_pkg::CFG_AGING_SHIFT:     ashift      <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (rsp_valid && rsp.ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end

      if (scanning) begin
        if (scan_done) begin
          iss  <= '0;
          pvld <= 1'b0;
        end else begin
          pvld <= issue;
          pidx <= iss[IW-1:0];
          if (issue) begin
            iss <= iss + CW'(1);
          end
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode_q    <= req.data.mode;
            aligned_q <= aligned_in;
            pick_q    <= req.data.random_pick;
            lfu_q     <= (policy == actr_pkg::POL_LFU);
            age       <= 1'b0;
            hit_f     <= 1'b0;
            alloc_f   <= 1'b0;
            evict_f   <= 1'b0;
            new_ent   <= 1'b0;
            wb_f      <= 1'b0;
            re_valid  <= 1'b0;
            rstar_f   <= 1'b0;
            pmin_f    <= 1'b0;
            e         <= '0;
            slen      <= next_free;
            if (req.data.mode == actr_pkg::MODE_READ) begin
              rc <= rc + 16'd1;
              if ((policy == actr_pkg::POL_LFU) && (aint != 16'd0)) begin
                div_a     <= rc + 16'd1;
                div_b     <= aint;
                div_start <= 1'b1;
                state     <= S_AGEDIV;
              end else begin
                state <= S_SCANA;
              end
            end else if ((req.data.mode == actr_pkg::MODE_WRITE) ||
                         (req.data.mode == actr_pkg::MODE_REVEAL)) begin
              state <= S_SCANA;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_AGEDIV: begin
          if (div_done) begin
            age   <= (div_rem == 16'd0);
            state <= S_SCANA;
          end
        end

        // tag compare, aging write-back, tail of the usage order
        S_SCANA: begin
          if (pvld) begin
            if (!hit_f && (rd.tag == aligned_q)) begin
              hit_f    <= 1'b1;
              hit_idx  <= pidx;
              hit_freq <= fa;
              hit_rank <= rd.rank;
            end
            if (rd.rank == IW'(NUM_ENTRIES - 1)) begin
              tail_freq <= fa;
            end
          end
          if (scan_done) begin
            slen <= next_free;
            if (hit_f) begin
              e        <= hit_idx;
              f_new    <= lfu_q ? actr_pkg::freq_inc(hit_freq, fmax) : hit_freq;
              re_valid <= 1'b1;
              re       <= hit_rank;
              state    <= S_SCAND;
            end else if (alloc_req) begin
              alloc_f <= 1'b1;
              f_new   <= actr_pkg::freq_inc(init_clamped, fmax);
              if (!full) begin
                e       <= next_free[IW-1:0];
                new_ent <= 1'b1;
                state   <= S_SCAND;
              end else begin
                evict_f <= 1'b1;
                slen    <= CW'(NUM_ENTRIES);
                if (policy == actr_pkg::POL_RANDOM) begin
                  by_rank <= 1'b0;
                  tgt     <= IW'(pick_rem);
                  state   <= S_SCANC;
                end else if (lfu_q) begin
                  least <= tail_freq;
                  state <= S_SCANB;
                end else begin
                  by_rank <= 1'b1;
                  tgt     <= IW'(NUM_ENTRIES - 1);
                  state   <= S_SCANC;
                end
              end
            end else begin
              state <= S_OUT;
            end
          end
        end

        // length of the run of least counts at the tail
        S_SCANB: begin
          if (pvld && (rd.freq != least) && (!rstar_f || (rd.rank > rstar))) begin
            rstar_f <= 1'b1;
            rstar   <= rd.rank;
          end
          if (scan_done) begin
            div_a     <= pick_q;
            div_b     <= 16'(cnt);
            div_start <= 1'b1;
            state     <= S_PICKDIV;
          end
        end

        S_PICKDIV: begin
          if (div_done) begin
            by_rank <= 1'b1;
            tgt     <= IW'(NUM_ENTRIES - 1) - div_rem[IW-1:0];
            state   <= S_SCANC;
          end
        end

        // fetch the victim
        S_SCANC: begin
          if (pvld && (by_rank ? (rd.rank == tgt) : (pidx == tgt))) begin
            e        <= pidx;
            vtag     <= rd.tag;
            re       <= rd.rank;
            re_valid <= 1'b1;
          end
          if (scan_done) begin
            slen  <= next_free;
            state <= S_SCAND;
          end
        end

        // insertion point: first entry whose count is not larger
        S_SCAND: begin
          if (pvld && (pidx != e) && lfu_q && (rd.freq <= f_new) &&
              (!pmin_f || (pos < pmin))) begin
            pmin_f <= 1'b1;
            pmin   <= pos;
          end
          if (scan_done) begin
            if (!lfu_q) begin
              p <= '0;
            end else if (pmin_f) begin
              p <= CW'(pmin);
            end else begin
              p <= nprime;
            end
            slen  <= next_free + CW'(new_ent);
            state <= S_SCANE;
          end
        end

        S_SCANE: begin
          if (scan_done) begin
            if (hit_f) begin
              if ((mode_q == actr_pkg::MODE_WRITE) && wbm) begin
                dirty[e] <= 1'b1;
              end
            end else begin
              dirty[e] <= (mode_q == actr_pkg::MODE_WRITE);
            end
            wb_f      <= evict_f && wbm && dirty[e];
            next_free <= next_free + CW'(new_ent);
            state     <= S_OUT;
          end
        end

        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid                  <= 1'b1;
            rsp_data.hit               <= hit_f;
            rsp_data.entry_index       <= (hit_f || alloc_f) ? e_wide[3:0] : 4'd0;
            rsp_data.allocated         <= alloc_f;
            rsp_data.fill_address      <= alloc_f ? aligned_q : 32'd0;
            rsp_data.writeback_needed  <= wb_f;
            rsp_data.writeback_address <= wb_f ? vtag : 32'd0;
            rsp_data.forward_write     <= (mode_q == actr_pkg::MODE_REVEAL) ||
                                          ((mode_q == actr_pkg::MODE_WRITE) && !wbm);
            state                      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `ACTR_ASSERT_NOW(a_fill_bound, 1'b1, next_free <= CW'(NUM_ENTRIES), "fill count beyond depth")
  `ACTR_ASSERT_NOW(a_hit_or_alloc, rsp_valid, !(rsp_data.hit && rsp_data.allocated), "hit and fill together")
  `ACTR_ASSERT_NOW(a_wb_needs_alloc, rsp_valid && rsp_data.writeback_needed, rsp_data.allocated && wbm, "write-back without eviction")
  `ACTR_ASSERT_NEXT(a_leave_idle, req.valid && req.ready, state != S_IDLE, "item taken but sequencer idle")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NE = 16;
  localparam int IDLE_LIMIT = 5000;

  // expected lookup results and a private copy of the tag store
  class tag_scoreboard;
    actr_pkg::rsp_t want_q[$];
    int          errors;
    logic        wb_mode;
    logic [1:0]  policy;
    logic [3:0]  off_bits;
    logic [4:0]  cnt_bits;
    logic [15:0] init_cnt, age_every;
    logic [3:0]  age_shift;
    logic [31:0] tag [NE];
    logic        vld [NE];
    logic        dirty [NE];
    logic [15:0] cnt [NE];
    int          rank [NE];
    int          n_used;
    logic [15:0] reads;

    function new();
      errors = 0;
      wb_mode = 0; policy = actr_pkg::POL_LRU; off_bits = 6; cnt_bits = 8;
      init_cnt = 0; age_every = 256; age_shift = 1;
      for (int i = 0; i < NE; i++) begin
        tag[i] = 0; vld[i] = 0; dirty[i] = 0; cnt[i] = 0; rank[i] = 0;
      end
      n_used = 0; reads = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        actr_pkg::CFG_WRITE_BACK_MODE: wb_mode = v[0];
        actr_pkg::CFG_REPLACE_POLICY:  policy = v[1:0];
        actr_pkg::CFG_OFFSET_BITS:     off_bits = v[3:0];
        actr_pkg::CFG_FREQ_COUNT_BITS: cnt_bits = v[4:0];
        actr_pkg::CFG_FREQ_INIT_VALUE: init_cnt = v;
        actr_pkg::CFG_AGING_INTERVAL:  age_every = v;
        actr_pkg::CFG_AGING_SHIFT:     age_shift = v[3:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] cnt_ceiling();
      int b;
      b = cnt_bits;
      if (b == 0) b = 1;
      if (b > 16) b = 16;
      return 16'((32'd1 << b) - 1);
    endfunction

    function logic [15:0] bump(logic [15:0] f);
      logic [15:0] m;
      m = cnt_ceiling();
      return (f < m) ? f + 16'd1 : m;
    endfunction

    // valid entries from head to tail, leaving out one entry
    function int usage_order(ref int ord[NE], input int skip);
      int slot [NE];
      bit taken [NE];
      int n;
      n = 0;
      for (int i = 0; i < NE; i++) taken[i] = 0;
      for (int i = 0; i < NE; i++)
        if (vld[i] && rank[i] < NE) begin
          slot[rank[i]] = i;
          taken[rank[i]] = 1;
        end
      for (int i = 0; i < NE; i++)
        if (taken[i] && slot[i] != skip) begin
          ord[n] = slot[i];
          n++;
        end
      return n;
    endfunction

    function void place(int e);
      int ord [NE];
      int n, p;
      n = usage_order(ord, e);
      p = 0;
      if (policy == actr_pkg::POL_LFU)
        while (p < n && cnt[ord[p]] > cnt[e]) p++;
      for (int i = 0; i < n; i++) rank[ord[i]] = (i < p) ? i : i + 1;
      rank[e] = p;
      vld[e] = 1;
    endfunction

    function int choose_victim(logic [15:0] pick);
      int ord [NE];
      int n, ties;
      logic [15:0] least;
      n = usage_order(ord, NE);
      if (n == 0) return 0;
      if (policy == actr_pkg::POL_RANDOM) return pick % NE;
      if (policy != actr_pkg::POL_LFU) return ord[n-1];
      least = cnt[ord[n-1]];
      ties = 0;
      while (ties < n && cnt[ord[n-1-ties]] == least) ties++;
      return ord[n-1-(pick % ties)];
    endfunction

    function void note(actr_pkg::req_t r);
      actr_pkg::rsp_t o;
      logic [31:0] blk;
      logic [15:0] m, ini;
      int e;
      o = '0;
      e = NE;
      if (r.mode == actr_pkg::MODE_READ || r.mode == actr_pkg::MODE_WRITE ||
          r.mode == actr_pkg::MODE_REVEAL) begin
        blk = r.address & ~((32'd1 << off_bits) - 32'd1);
        if (r.mode == actr_pkg::MODE_READ) begin
          reads = reads + 16'd1;
          if (policy == actr_pkg::POL_LFU && age_every != 0 && reads % age_every == 0)
            for (int i = 0; i < NE; i++)
              if (vld[i]) cnt[i] = cnt[i] >> age_shift;
        end
        for (int i = 0; i < NE; i++)
          if (e == NE && vld[i] && tag[i] == blk) e = i;
        if (e < NE) begin
          if (policy == actr_pkg::POL_LFU) cnt[e] = bump(cnt[e]);
          place(e);
          if (r.mode == actr_pkg::MODE_WRITE && wb_mode) dirty[e] = 1;
          o.hit = 1;
          o.entry_index = 4'(e);
        end else if (r.mode == actr_pkg::MODE_READ ||
                     (r.mode == actr_pkg::MODE_WRITE && wb_mode)) begin
          if (n_used < NE) begin
            e = n_used;
            n_used++;
          end else begin
            e = choose_victim(r.random_pick);
            if (wb_mode && dirty[e]) begin
              o.writeback_needed = 1;
              o.writeback_address = tag[e];
            end
          end
          dirty[e] = (r.mode == actr_pkg::MODE_WRITE);
          tag[e] = blk;
          m = cnt_ceiling();
          ini = (init_cnt < m) ? init_cnt : m;
          cnt[e] = bump(ini);
          place(e);
          o.entry_index = 4'(e);
          o.allocated = 1;
          o.fill_address = blk;
        end
        o.forward_write = (r.mode == actr_pkg::MODE_REVEAL ||
                           (r.mode == actr_pkg::MODE_WRITE && !wb_mode));
      end
      want_q.push_back(o);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check(actr_pkg::rsp_t a);
      actr_pkg::rsp_t w;
      if (want_q.size() == 0) begin
        $error("unexpected result item %p", a);
        errors++;
        return;
      end
      w = want_q.pop_front();
      cmp("hit", 32'(w.hit), 32'(a.hit));
      cmp("entry_index", 32'(w.entry_index), 32'(a.entry_index));
      cmp("allocated", 32'(w.allocated), 32'(a.allocated));
      cmp("fill_address", w.fill_address, a.fill_address);
      cmp("writeback_needed", 32'(w.writeback_needed), 32'(a.writeback_needed));
      cmp("writeback_address", w.writeback_address, a.writeback_address);
      cmp("forward_write", 32'(w.forward_write), 32'(a.forward_write));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  actr_chan_if #(.payload_t(actr_pkg::req_t)) req_if ();
  actr_chan_if #(.payload_t(actr_pkg::rsp_t)) rsp_if ();

  assoc_cache_tag_replacement #(.NUM_ENTRIES(NE)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tag_scoreboard sb = new();
  bit            hold_rsp;
  int            idle_cycles;
  logic [31:0]   blk_pool [32];
  int            pool_n;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
  end

  // result sink with random stalls, and one long hold-off on request
  initial begin
    int g;
    rsp_if.ready = 0;
    @(negedge rst);
    forever begin
      g = $urandom_range(0, 7);
      if (hold_rsp) begin
        hold_rsp = 0;
        g = 300;
      end
      if (g > 0) begin
        rsp_if.ready <= 0;
        repeat (g) @(posedge clk);
      end
      rsp_if.ready <= 1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(actr_pkg::req_t r);
    int g;
    g = $urandom_range(0, 7);
    if (g > 0) begin
      req_if.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req_if.valid <= 1;
    req_if.data <= r;
    do @(posedge clk); while (!req_if.ready);
    sb.note(r);
  endtask

  task automatic send(logic [1:0] m, logic [31:0] a, logic [15:0] p);
    actr_pkg::req_t r;
    r.mode = m;
    r.address = a;
    r.random_pick = p;
    send_item(r);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.want_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(logic wb, logic [1:0] pol, logic [3:0] ob, logic [4:0] cb,
                       logic [15:0] ini, logic [15:0] ival, logic [3:0] sh);
    logic [15:0] v [7];
    v[0] = 16'(wb); v[1] = 16'(pol); v[2] = 16'(ob); v[3] = 16'(cb);
    v[4] = ini; v[5] = ival; v[6] = 16'(sh);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= v[i];
      @(posedge clk);
      sb.set_reg(3'(i), v[i]);
    end
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count, bit long_hold, bit mid_pause);
    actr_pkg::req_t r;
    int k;
    pool_n = $urandom_range(10, 32);
    for (int i = 0; i < pool_n; i++) blk_pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if (long_hold && i == 10) hold_rsp = 1;
      if (mid_pause && i == count / 2) drain();
      k = $urandom_range(0, 9);
      r.mode = (k < 5) ? actr_pkg::MODE_READ :
               (k < 8) ? actr_pkg::MODE_WRITE : actr_pkg::MODE_REVEAL;
      if ($urandom_range(0, 9) == 0) r.address = $urandom;
      else r.address = blk_pool[$urandom_range(0, pool_n - 1)] ^ 32'($urandom_range(0, 4095));
      r.random_pick = 16'($urandom_range(0, 65535));
      send_item(r);
    end
    drain();
  endtask

  initial begin
    req_if.valid = 0;
    req_if.data = '0;
    cfg_we = 0;
    cfg_index = actr_pkg::CFG_WRITE_BACK_MODE;
    cfg_data = 0;
    @(negedge rst);
    @(posedge clk);
    // directed: write-through, then write-back with a fill of every entry and an eviction
    setup(0, actr_pkg::POL_LRU, 0, 8, 0, 256, 1);
    send(actr_pkg::MODE_READ, 32'h0000_0000, 16'h0000);
    send(actr_pkg::MODE_READ, 32'hFFFF_FFFF, 16'hFFFF);
    send(actr_pkg::MODE_WRITE, 32'hFFFF_FFFF, 16'h0000);
    send(actr_pkg::MODE_WRITE, 32'h1234_5678, 16'h0000);
    send(actr_pkg::MODE_REVEAL, 32'h0000_0000, 16'h0000);
    send(actr_pkg::MODE_REVEAL, 32'hAAAA_5555, 16'h0000);
    send(actr_pkg::MODE_READ, 32'hFFFF_FFFF, 16'h0000);
    drain();
    setup(1, actr_pkg::POL_LRU, 12, 16, 16'hFFFF, 1, 15);
    for (int i = 0; i < 17; i++)
      send((i % 2) ? actr_pkg::MODE_WRITE : actr_pkg::MODE_READ,
           32'(i) << 12 | 32'hFFF, 16'hFFFF);
    send(actr_pkg::MODE_WRITE, 32'h0000_2000, 16'h0000);
    drain();

    random_phase(70, 0, 0);
    setup(1, actr_pkg::POL_LFU, 6, 1, 0, 1, 1);
    random_phase(70, 1, 0);
    setup(1, actr_pkg::POL_LFU, 4, 16, 16'hFFFF, 65535, 15);
    random_phase(70, 0, 1);
    setup(0, actr_pkg::POL_RANDOM, 12, 8, 3, 256, 1);
    random_phase(70, 0, 0);
    setup(1, actr_pkg::POL_RANDOM, 0, 4, 2, 7, 2);
    random_phase(70, 0, 0);
    setup(1, actr_pkg::POL_LFU, 8, 3, 16'h00FF, 5, 1);
    random_phase(70, 0, 0);
    setup(1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)), 4'($urandom_range(0, 12)),
          5'($urandom_range(1, 16)), 16'($urandom_range(0, 65535)),
          16'($urandom_range(1, 64)), 4'($urandom_range(1, 15)));
    random_phase(70, 0, 0);

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== assoc_cache_tag_replacement.f =====
+incdir+hdl
hdl/actr_pkg.sv
hdl/actr_chan_if.sv
hdl/actr_mem.sv
hdl/actr_div.sv
hdl/assoc_cache_tag_replacement.sv
tb/sv/testbench.sv
